[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define STB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed in same cycle");

// next-cycle implication, sampled on clk, off while in reset
`define STB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("implication failed in next cycle");

`endif

[rtl/core/stb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stb_pkg
// Types, codes and character constants for the serial terminal ring buffers.
// ---------------------------------------------------------------------------
package stb_pkg;

    localparam int TX_DEPTH_DEF = 256;
    localparam int RX_DEPTH_DEF = 16;
    localparam int BYTE_W       = 8;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 1;

    // operation codes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_PUT        = 3'd0,
        OP_GET        = 3'd1,
        OP_LINE_RX    = 3'd2,
        OP_LINE_READY = 3'd3,
        OP_CLEAR_RX   = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_DROPPED = 2'd2
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ECHO_ENABLE      = 1'b0,
        CFG_ARROW_MAP_ENABLE = 1'b1
    } cfg_index_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LF_SECOND,
        ST_READ,
        ST_DONE
    } state_t;

    // character constants
    localparam logic [BYTE_W-1:0] CHAR_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CHAR_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_UP       = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_DOWN     = 8'h42;
    localparam logic [BYTE_W-1:0] CHAR_RIGHT    = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_LEFT     = 8'h44;
    localparam logic [BYTE_W-1:0] CHAR_W        = 8'h77;
    localparam logic [BYTE_W-1:0] CHAR_S        = 8'h73;
    localparam logic [BYTE_W-1:0] CHAR_D        = 8'h64;
    localparam logic [BYTE_W-1:0] CHAR_A        = 8'h61;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   out_byte;
        logic                out_valid;
        logic                rx_has_data;
        logic                overrun;
        logic                tx_pending;
    } out_item_t;

    // ring control and status between the sequencer and a ring
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } ring_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    // escape arrow sequence mapping on the byte being returned
    function automatic logic [BYTE_W-1:0] arrow_map(
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] older,
        input logic [BYTE_W-1:0] newer
    );
        logic [BYTE_W-1:0] r;
        r = b;
        if (older == CHAR_ESC && newer == CHAR_LBRACKET)
        begin
            case (b)
                CHAR_UP:    r = CHAR_W;
                CHAR_DOWN:  r = CHAR_S;
                CHAR_RIGHT: r = CHAR_D;
                CHAR_LEFT:  r = CHAR_A;
                default:    r = b;
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/core/stb_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = stb_pkg::BYTE_W,
    parameter int DEPTH = stb_pkg::RX_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/stb_ring.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stb_ring
// Byte ring: write and read pointers and a fill count around one memory.
// ---------------------------------------------------------------------------
module stb_ring #(
    parameter int DEPTH = stb_pkg::RX_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stb_pkg::ring_ctrl_t         ctrl,
    input  logic [stb_pkg::BYTE_W-1:0]  wdata,
    output logic [stb_pkg::BYTE_W-1:0]  rdata,
    output stb_pkg::ring_stat_t         stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;

    // pointer and count update, wrapping at the ring depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_next = count_reg + CW'(1);
                2'b01:   count_next = count_reg - CW'(1);
                default: count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // ring storage
    stb_ram #(
        .WIDTH (stb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_ptr_reg),
        .wdata (wdata),
        .re    (do_pop),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

endmodule

[rtl/core/serial_terminal_ring_buffers_top.sv]
`timescale 1ns / 1ps
// An accepted item passes ST_READ first for a get or line ready that pops a byte,
// and ST_LF_SECOND first for a put or echo that writes a line feed pair; the
// registered result beat is issued from ST_DONE, which waits out an output stall.
// One item at a time: in_stall holds new items off until the state is ST_IDLE again.
// Reset (asynchronous, active low) clears pointers, counts, flags and the arrow
// history; ring memory contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// serial_terminal_ring_buffers_top
// Transmit and receive byte rings with line feed expansion, echo, overrun
// flag and escape arrow mapping, driven by a small sequencer.
// ---------------------------------------------------------------------------
module serial_terminal_ring_buffers_top #(
    parameter int TX_DEPTH = stb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = stb_pkg::RX_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  stb_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output stb_pkg::out_item_t              out_item,
    input  logic                            cfg_we,
    input  logic [stb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    stb_pkg::state_t    state_reg, state_next;
    stb_pkg::op_t       op_reg, op_next;
    stb_pkg::ring_ctrl_t tx_ctrl, rx_ctrl;
    stb_pkg::ring_stat_t tx_stat, rx_stat;

    logic [stb_pkg::BYTE_W-1:0]   tx_wdata, rx_wdata, tx_rdata, rx_rdata;
    logic [stb_pkg::BYTE_W-1:0]   older_reg, older_next, newer_reg, newer_next;
    logic [stb_pkg::BYTE_W-1:0]   got_byte;
    logic [stb_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [stb_pkg::BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic                         res_valid_reg, res_valid_next;
    logic                         overrun_reg, overrun_next;
    logic                         echo_reg, arrow_reg;
    logic                         out_valid_reg, out_valid_next;
    stb_pkg::out_item_t           out_item_reg, out_item_next;
    logic                         accept, out_free, echo_go, in_is_lf;

    assign accept   = in_valid && (state_reg == stb_pkg::ST_IDLE);
    assign in_stall = (state_reg != stb_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign echo_go  = echo_reg && !tx_stat.full;
    assign in_is_lf = (in_item.data_byte == stb_pkg::CHAR_LF);
    assign got_byte = arrow_reg ? stb_pkg::arrow_map(rx_rdata, older_reg, newer_reg)
                                : rx_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg  <= 1'b0;
            arrow_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stb_pkg::CFG_ECHO_ENABLE:      echo_reg  <= cfg_data[0];
                stb_pkg::CFG_ARROW_MAP_ENABLE: arrow_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = stb_pkg::ST_DONE;
                    unique case (in_item.operation)
                        stb_pkg::OP_PUT:
                            if (in_is_lf) state_next = stb_pkg::ST_LF_SECOND;
                        stb_pkg::OP_GET:
                            if (!rx_stat.empty) state_next = stb_pkg::ST_READ;
                        stb_pkg::OP_LINE_RX:
                            if (echo_go && in_is_lf) state_next = stb_pkg::ST_LF_SECOND;
                        stb_pkg::OP_LINE_READY:
                            if (!tx_stat.empty) state_next = stb_pkg::ST_READ;
                        default:
                            state_next = stb_pkg::ST_DONE;
                    endcase
                end
            end
            stb_pkg::ST_LF_SECOND: state_next = stb_pkg::ST_DONE;
            stb_pkg::ST_READ:      state_next = stb_pkg::ST_DONE;
            stb_pkg::ST_DONE:
                if (out_free) state_next = stb_pkg::ST_IDLE;
            default:               state_next = stb_pkg::ST_IDLE;
        endcase
    end

    // ring control, result and flag updates
    always_comb
    begin
        tx_ctrl         = '0;
        rx_ctrl         = '0;
        tx_wdata        = in_is_lf ? stb_pkg::CHAR_CR : in_item.data_byte;
        rx_wdata        = (in_item.data_byte == stb_pkg::CHAR_CR) ? stb_pkg::CHAR_LF
                                                                  : in_item.data_byte;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        res_valid_next  = res_valid_reg;
        overrun_next    = overrun_reg;
        older_next      = older_reg;
        newer_next      = newer_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_item_next   = out_item_reg;
        unique case (state_reg)
            stb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = stb_pkg::op_t'(in_item.operation);
                    res_status_next = stb_pkg::STATUS_OK;
                    res_byte_next   = '0;
                    res_valid_next  = 1'b0;
                    unique case (in_item.operation)
                        stb_pkg::OP_PUT:
                        begin
                            tx_ctrl.push = 1'b1;
                            if (!in_is_lf && tx_stat.full)
                            begin
                                res_status_next = stb_pkg::STATUS_DROPPED;
                            end
                        end
                        stb_pkg::OP_GET:
                        begin
                            if (rx_stat.empty)
                            begin
                                res_status_next = stb_pkg::STATUS_EMPTY;
                            end
                            rx_ctrl.pop = 1'b1;
                        end
                        stb_pkg::OP_LINE_RX:
                        begin
                            tx_ctrl.push = echo_go;
                            if (rx_stat.full)
                            begin
                                overrun_next    = 1'b1;
                                res_status_next = stb_pkg::STATUS_DROPPED;
                            end
                            rx_ctrl.push = 1'b1;
                        end
                        stb_pkg::OP_LINE_READY:
                        begin
                            if (tx_stat.empty)
                            begin
                                res_status_next = stb_pkg::STATUS_EMPTY;
                            end
                            tx_ctrl.pop = 1'b1;
                        end
                        stb_pkg::OP_CLEAR_RX:
                            rx_ctrl.clear = 1'b1;
                        default:
                            ;
                    endcase
                end
            end
            // second entry of a carriage return and line feed pair
            stb_pkg::ST_LF_SECOND:
            begin
                tx_wdata     = stb_pkg::CHAR_LF;
                tx_ctrl.push = 1'b1;
                if (op_reg == stb_pkg::OP_PUT && tx_stat.full)
                begin
                    res_status_next = stb_pkg::STATUS_DROPPED;
                end
            end
            // read data from the popped ring
            stb_pkg::ST_READ:
            begin
                res_valid_next = 1'b1;
                if (op_reg == stb_pkg::OP_GET)
                begin
                    res_byte_next = got_byte;
                    older_next    = newer_reg;
                    newer_next    = got_byte;
                end
                else
                begin
                    res_byte_next = tx_rdata;
                end
            end
            stb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.status      = res_status_reg;
                    out_item_next.out_byte    = res_byte_reg;
                    out_item_next.out_valid   = res_valid_reg;
                    out_item_next.rx_has_data = !rx_stat.empty;
                    out_item_next.overrun     = overrun_reg;
                    out_item_next.tx_pending  = !tx_stat.empty;
                end
            end
            default:
                ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stb_pkg::ST_IDLE;
            op_reg        <= stb_pkg::OP_PUT;
            overrun_reg   <= 1'b0;
            older_reg     <= '0;
            newer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            overrun_reg   <= overrun_next;
            older_reg     <= older_next;
            newer_reg     <= newer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_valid_reg  <= res_valid_next;
        out_item_reg   <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // transmit ring
    stb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tx_ctrl),
        .wdata (tx_wdata),
        .rdata (tx_rdata),
        .stat  (tx_stat)
    );

    // receive ring
    stb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rx_ctrl),
        .wdata (rx_wdata),
        .rdata (rx_rdata),
        .stat  (rx_stat)
    );

endmodule

[rtl/core/stb_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stb_checker
// Port-level checks on the serial terminal ring buffers, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input stb_pkg::in_item_t               in_item,
    input logic                            out_valid,
    input logic                            out_stall,
    input stb_pkg::out_item_t              out_item,
    input logic                            cfg_we,
    input logic [stb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [stb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [1:0] inflight_reg, inflight_next;
    logic       seen_overrun_reg;
    logic       in_acc, out_acc, cfg_seen;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;
    assign cfg_seen = cfg_we && (cfg_index == cfg_index) && (cfg_data == cfg_data)
                      && (in_item == in_item);

    // items accepted whose result beat is not yet taken
    always_comb
    begin
        inflight_next = inflight_reg;
        case ({in_acc, out_acc})
            2'b10:   inflight_next = inflight_reg + 2'd1;
            2'b01:   inflight_next = inflight_reg - 2'd1;
            default: inflight_next = inflight_reg;
        endcase
    end

    // in-flight count, and overrun once delivered stays set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg     <= 2'd0;
            seen_overrun_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (out_acc && out_item.overrun)
            begin
                seen_overrun_reg <= 1'b1;
            end
        end
    end

    `STB_ASSERT_IMP(a_result_has_item, out_valid || cfg_seen, inflight_reg != 2'd0 || !out_valid)
    `STB_ASSERT_IMP(a_inflight_bound, 1'b1, inflight_reg != 2'd3)
    `STB_ASSERT_IMP(a_overrun_sticky, out_valid && seen_overrun_reg, out_item.overrun)
    `STB_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall)
    `STB_ASSERT_NXT(a_stalled_beat_holds, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

bind serial_terminal_ring_buffers_top stb_checker u_stb_checker (.*);

[verif/serial_terminal_ring_buffers_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_terminal_ring_buffers_top_test
// Self-checking test of the terminal ring pair. Input beats are driven with
// random gaps and output stalls. Each accepted beat runs through a local
// model of both rings, the arrow history and the flags. Each result beat is
// compared field by field with the oldest predicted result.
// ---------------------------------------------------------------------------
module serial_terminal_ring_buffers_top_test;
    import stb_pkg::*;

    localparam int TX_SIZE        = TX_DEPTH_DEF;
    localparam int RX_SIZE        = RX_DEPTH_DEF;
    localparam int OP_CODE_LAST   = 7;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int MAX_REPORTS    = 10;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_item;
    logic       cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // local copy of the terminal state
    logic [BYTE_W-1:0] tx_ring [TX_SIZE];
    logic [BYTE_W-1:0] rx_ring [RX_SIZE];
    int                tx_wr        = 0;
    int                tx_level     = 0;
    int                rx_wr        = 0;
    int                rx_level     = 0;
    bit                overrun_seen = 1'b0;
    logic [BYTE_W-1:0] got_older    = '0;
    logic [BYTE_W-1:0] got_newer    = '0;
    bit                echo_on      = 1'b0;
    bit                arrow_on     = 1'b1;

    out_item_t pending_terminal_results[$];
    int        mismatches      = 0;
    int        beats_sent      = 0;
    int        holdoff_request = 0;
    int        idle_cycles     = 0;
    bit        send_idling     = 1'b0;
    bit        recv_idling     = 1'b0;

    serial_terminal_ring_buffers_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------------
    // terminal model
    // ---------------------------------------------------------------------
    function automatic bit tx_ring_push(input logic [BYTE_W-1:0] b);
        if (tx_level >= TX_SIZE)
            return 1'b0;
        tx_ring[tx_wr] = b;
        tx_wr = (tx_wr + 1) % TX_SIZE;
        tx_level++;
        return 1'b1;
    endfunction

    // a line feed goes in behind a carriage return
    function automatic bit tx_ring_put(input logic [BYTE_W-1:0] b);
        if (b == CHAR_LF)
            void'(tx_ring_push(CHAR_CR));
        return tx_ring_push(b);
    endfunction

    function automatic logic [BYTE_W-1:0] decode_arrow(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (got_older == CHAR_ESC && got_newer == CHAR_LBRACKET)
        begin
            case (b)
                CHAR_UP:    r = CHAR_W;
                CHAR_DOWN:  r = CHAR_S;
                CHAR_RIGHT: r = CHAR_D;
                CHAR_LEFT:  r = CHAR_A;
                default:    r = b;
            endcase
        end
        return r;
    endfunction

    function automatic out_item_t predict_terminal_step(input in_item_t beat);
        out_item_t         r;
        logic [BYTE_W-1:0] b;
        int                rd;
        r = '0;
        b = beat.data_byte;
        case (beat.operation)
            OP_PUT:
            begin
                if (!tx_ring_put(b))
                    r.status = STATUS_DROPPED;
            end
            OP_GET:
            begin
                if (rx_level == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    rd = (rx_wr + RX_SIZE - rx_level) % RX_SIZE;
                    b = rx_ring[rd];
                    rx_level--;
                    if (arrow_on)
                        b = decode_arrow(b);
                    got_older = got_newer;
                    got_newer = b;
                    r.out_byte  = b;
                    r.out_valid = 1'b1;
                end
            end
            OP_LINE_RX:
            begin
                // echo is lost silently when the transmit ring is full
                if (echo_on && tx_level < TX_SIZE)
                    void'(tx_ring_put(b));
                if (rx_level >= RX_SIZE)
                begin
                    overrun_seen = 1'b1;
                    r.status = STATUS_DROPPED;
                end
                else
                begin
                    rx_ring[rx_wr] = (b == CHAR_CR) ? CHAR_LF : b;
                    rx_wr = (rx_wr + 1) % RX_SIZE;
                    rx_level++;
                end
            end
            OP_LINE_READY:
            begin
                if (tx_level == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    rd = (tx_wr + TX_SIZE - tx_level) % TX_SIZE;
                    r.out_byte  = tx_ring[rd];
                    r.out_valid = 1'b1;
                    tx_level--;
                end
            end
            OP_CLEAR_RX:
            begin
                rx_wr    = 0;
                rx_level = 0;
            end
            default: ;
        endcase
        r.rx_has_data = (rx_level != 0);
        r.overrun     = overrun_seen;
        r.tx_pending  = (tx_level != 0);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // sender: one input beat, predicted when accepted
    // ---------------------------------------------------------------------
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        in_item_t beat;
        beat.operation = op;
        beat.data_byte = data;
        if (send_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        pending_terminal_results.push_back(predict_terminal_step(beat));
        beats_sent++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_terminal_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_register(input cfg_index_t idx, input logic value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ECHO_ENABLE:      echo_on  = value;
            CFG_ARROW_MAP_ENABLE: arrow_on = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // bytes biased towards the ones with special handling
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 13))
            0:       return CHAR_LF;
            1:       return CHAR_CR;
            2:       return CHAR_ESC;
            3:       return CHAR_LBRACKET;
            4:       return CHAR_UP;
            5:       return CHAR_DOWN;
            6:       return CHAR_RIGHT;
            7:       return CHAR_LEFT;
            8:       return 8'h00;
            9:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_arrow_letter();
        case ($urandom_range(0, 4))
            0:       return CHAR_UP;
            1:       return CHAR_DOWN;
            2:       return CHAR_RIGHT;
            3:       return CHAR_LEFT;
            default: return pick_byte();
        endcase
    endfunction

    // one random beat, or an escape sequence received and read back
    task automatic send_random_beat();
        int choice;
        choice = $urandom_range(0, 99);
        if (choice < 8)
        begin
            send_beat(OP_LINE_RX, CHAR_ESC);
            send_beat(OP_LINE_RX, ($urandom_range(0, 5) == 0) ? pick_byte() : CHAR_LBRACKET);
            send_beat(OP_LINE_RX, pick_arrow_letter());
            while (rx_level != 0)
                send_beat(OP_GET, 8'($urandom));
        end
        else if (choice < 30)
            send_beat(OP_PUT, pick_byte());
        else if (choice < 50)
            send_beat(OP_GET, 8'($urandom));
        else if (choice < 72)
            send_beat(OP_LINE_RX, pick_byte());
        else if (choice < 94)
            send_beat(OP_LINE_READY, 8'($urandom));
        else if (choice < 97)
            send_beat(OP_CLEAR_RX, 8'($urandom));
        else
            send_beat(OP_W'($urandom_range(OP_CLEAR_RX + 1, OP_CODE_LAST)), 8'($urandom));
    endtask

    task automatic random_traffic(input int count);
        int target;
        target = beats_sent + count;
        while (beats_sent < target)
            send_random_beat();
    endtask

    // ---------------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------------
    task automatic test_put_and_line_ready();
        send_beat(OP_PUT, 8'hFF);
        send_beat(OP_PUT, CHAR_LF);
        repeat (3) send_beat(OP_LINE_READY, 8'h00);
        send_beat(OP_LINE_READY, 8'hFF);
    endtask

    task automatic test_receive_and_get();
        send_beat(OP_LINE_RX, CHAR_CR);
        send_beat(OP_LINE_RX, 8'h00);
        repeat (3) send_beat(OP_GET, 8'hFF);
    endtask

    task automatic test_arrow_keys();
        send_beat(OP_LINE_RX, CHAR_ESC);
        send_beat(OP_LINE_RX, CHAR_LBRACKET);
        send_beat(OP_LINE_RX, CHAR_UP);
        repeat (3) send_beat(OP_GET, 8'h00);
    endtask

    task automatic test_unused_operations();
        for (int code = OP_CLEAR_RX + 1; code <= OP_CODE_LAST; code++)
            send_beat(OP_W'(code), 8'($urandom));
    endtask

    task automatic test_clear_receive_ring();
        send_beat(OP_LINE_RX, 8'h33);
        send_beat(OP_CLEAR_RX, 8'h00);
        send_beat(OP_GET, 8'h00);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_receiver_holdoff();
        send_idling = 1'b0;
        holdoff_request = HOLDOFF_CYCLES;
        random_traffic(30);
        send_idling = 1'b1;
    endtask

    // overrun stays set across a clear
    task automatic test_receive_overrun();
        while (rx_level < RX_SIZE)
            send_beat(OP_LINE_RX, pick_byte());
        repeat (2) send_beat(OP_LINE_RX, pick_byte());
        send_beat(OP_GET, 8'h00);
        send_beat(OP_CLEAR_RX, 8'h00);
        send_beat(OP_GET, 8'h00);
        send_beat(OP_LINE_RX, pick_byte());
        send_beat(OP_GET, 8'h00);
    endtask

    // history is kept while mapping is off and used once it is back on
    task automatic test_arrow_history_across_config();
        while (rx_level != 0)
            send_beat(OP_GET, 8'h00);
        send_beat(OP_LINE_RX, CHAR_ESC);
        send_beat(OP_LINE_RX, CHAR_LBRACKET);
        repeat (2) send_beat(OP_GET, 8'h00);
        drain_results();
        write_register(CFG_ARROW_MAP_ENABLE, 1'b1);
        send_beat(OP_LINE_RX, CHAR_RIGHT);
        send_beat(OP_GET, 8'h00);
    endtask

    // fill the transmit ring, hit its edges, then empty it
    task automatic test_transmit_ring_full();
        while (tx_level < TX_SIZE - 1)
        begin
            if (tx_level <= TX_SIZE - 3)
                send_beat(OP_PUT, $urandom_range(0, 1) ? CHAR_LF : pick_byte());
            else
                send_beat(OP_PUT, 8'h20);
        end
        // line feed with room for one entry
        send_beat(OP_PUT, CHAR_LF);
        send_beat(OP_LINE_READY, 8'h00);
        // echoed line feed with room for one, then echo into a full ring
        send_beat(OP_LINE_RX, CHAR_LF);
        send_beat(OP_LINE_RX, pick_byte());
        send_beat(OP_PUT, pick_byte());
        while (tx_level != 0)
            send_beat(OP_LINE_READY, 8'($urandom));
        send_beat(OP_LINE_READY, 8'($urandom));
        while (rx_level != 0)
            send_beat(OP_GET, 8'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // receiver: random stall bursts and the long hold-off
    // ---------------------------------------------------------------------
    always
    begin
        @(posedge clk);
        if (holdoff_request != 0)
        begin
            out_stall <= 1'b1;
            repeat (holdoff_request) @(posedge clk);
            holdoff_request = 0;
            out_stall <= 1'b0;
        end
        else if (recv_idling && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_terminal_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected: %p", $realtime, out_item);
            end
            else
            begin
                want = pending_terminal_results.pop_front();
                if (want.status !== out_item.status || want.out_byte !== out_item.out_byte
                    || want.out_valid !== out_item.out_valid
                    || want.rx_has_data !== out_item.rx_has_data
                    || want.overrun !== out_item.overrun
                    || want.tx_pending !== out_item.tx_pending)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch expected status %0d byte %02h valid %0b",
                                 $realtime, want.status, want.out_byte, want.out_valid);
                        $display("    avail %0b overrun %0b pending %0b",
                                 want.rx_has_data, want.overrun, want.tx_pending);
                        $display("  actual status %0d byte %02h valid %0b",
                                 out_item.status, out_item.out_byte, out_item.out_valid);
                        $display("    avail %0b overrun %0b pending %0b",
                                 out_item.rx_has_data, out_item.overrun,
                                 out_item.tx_pending);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat or write taken
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with reset settings
        test_put_and_line_ready();
        test_receive_and_get();
        test_arrow_keys();
        test_unused_operations();
        test_clear_receive_ring();

        // random traffic with idling on both sides
        send_idling = 1'b1;
        recv_idling = 1'b1;
        random_traffic(120);
        test_receiver_holdoff();
        drain_results();

        // echo on, mapping off
        write_register(CFG_ECHO_ENABLE, 1'b1);
        write_register(CFG_ARROW_MAP_ENABLE, 1'b0);
        test_receive_overrun();
        random_traffic(110);
        test_arrow_history_across_config();
        test_transmit_ring_full();
        drain_results();

        // last stretch without idling
        write_register(CFG_ECHO_ENABLE, 1'b0);
        write_register(CFG_ARROW_MAP_ENABLE, 1'b0);
        send_idling = 1'b0;
        recv_idling = 1'b0;
        random_traffic(120);
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending_terminal_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
